/* rtl/siab_pkg.sv */
// ----------------------------------------------------------------------------
// siab_pkg: shared types and constants of the scaled icon alpha blitter
// Item structs, configuration register codes, geometry bundle and helpers.
// ----------------------------------------------------------------------------
package siab_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_ICON_SIDE_DEF = 64;
  localparam int unsigned SLOT_SIZE_DEF     = 16;

  // Texel store address width (4096 entries).
  localparam int unsigned STORE_AW = 12;

  // Signed 14.16 framebuffer position width and integer bound width.
  localparam int unsigned XW = 30;
  localparam int unsigned BW = XW - 16;

  // Configuration port widths.
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 13;

  // Opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BLEND = 1'b1;

  // Alpha constants.
  localparam logic [7:0]  ALPHA_DIM   = 8'd144;
  localparam logic [7:0]  ALPHA_FULL  = 8'd255;
  localparam logic [7:0]  ALPHA_NONE  = 8'd0;
  localparam logic [16:0] ROUND_HALF  = 17'd127;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ICON_WIDTH  = 3'd0,
    CFG_ICON_HEIGHT = 3'd1,
    CFG_SLOT_LEFT   = 3'd2,
    CFG_SLOT_TOP    = 3'd3,
    CFG_CLIP_LEFT   = 3'd4,
    CFG_CLIP_TOP    = 3'd5,
    CFG_CLIP_RIGHT  = 3'd6,
    CFG_CLIP_BOTTOM = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        opcode;
    logic [11:0] texel_index;
    logic [31:0] texel_rgba;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] dest_rgba;
    logic        dimmed;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_rgba;
    logic        write_pixel;
  } out_item_t;

  // Placement of the icon.
  typedef struct packed {
    logic                 empty;
    logic signed [XW-1:0] draw_x;
    logic signed [XW-1:0] draw_y;
    logic signed [BW-1:0] x_lo;
    logic signed [BW-1:0] x_hi;
    logic signed [BW-1:0] y_lo;
    logic signed [BW-1:0] y_hi;
  } geom_t;

  // Exact floor(x / 255) for the value range used here (below 65280).
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] t;
    t = x + (x >> 8) + 17'd1;
    return t[15:8];
  endfunction

endpackage

/* rtl/scaled_icon_alpha_blit.sv */
// ----------------------------------------------------------------------------
// scaled_icon_alpha_blit: nearest-neighbor scaled icon blit with alpha blend
// Top level: configuration, coordinate pipeline and shading pipeline.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless it is held off or stalled by the
// output, and returns exactly one result per item, in order. The coordinate
// pipeline spends one stage per source-coordinate quotient bit, and the
// shading pipeline has five stages around the texel store port. After reset
// and after every configuration write the input side is held off while a
// bit-serial divider fits the icon into its slot. Configuration writes are
// always taken. The texel store has no clearing pass; blend only where
// texels were loaded.
module scaled_icon_alpha_blit #(
  parameter int unsigned MAX_ICON_SIDE = siab_pkg::MAX_ICON_SIDE_DEF,
  parameter int unsigned SLOT_SIZE     = siab_pkg::SLOT_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  siab_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output siab_pkg::out_item_t         out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [siab_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [siab_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned SW = $clog2(MAX_ICON_SIDE + 1);
  localparam int unsigned FW = $clog2(SLOT_SIZE + 1) + 16;

  logic               busy;
  siab_pkg::geom_t    geom;
  logic [SW-1:0]      width, height, sx, sy;
  logic [FW-1:0]      draw_w, draw_h;
  logic               crd_in_ready, crd_valid, crd_cover, shd_ready;
  siab_pkg::in_item_t crd_item;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = crd_in_ready && !busy;

  // Register file and icon placement.
  siab_geom #(
    .MAX_ICON_SIDE(MAX_ICON_SIDE),
    .SLOT_SIZE    (SLOT_SIZE)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .geom_o     (geom),
    .width_o    (width),
    .height_o   (height),
    .draw_w_o   (draw_w),
    .draw_h_o   (draw_h)
  );

  // Coverage and source coordinates.
  siab_coord #(
    .MAX_ICON_SIDE(MAX_ICON_SIDE),
    .SLOT_SIZE    (SLOT_SIZE)
  ) u_coord (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && !busy),
    .in_ready_o (crd_in_ready),
    .in_item_i  (in_item_i),
    .geom_i     (geom),
    .width_i    (width),
    .height_i   (height),
    .draw_w_i   (draw_w),
    .draw_h_i   (draw_h),
    .out_valid_o(crd_valid),
    .out_ready_i(shd_ready),
    .out_item_o (crd_item),
    .out_cover_o(crd_cover),
    .out_sx_o   (sx),
    .out_sy_o   (sy)
  );

  // Texel store and blend.
  siab_shade #(
    .MAX_ICON_SIDE(MAX_ICON_SIDE)
  ) u_shade (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (crd_valid),
    .in_ready_o (shd_ready),
    .in_item_i  (crd_item),
    .in_cover_i (crd_cover),
    .in_sx_i    (sx),
    .in_sy_i    (sy),
    .width_i    (width),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

/* rtl/siab_geom.sv */
// ----------------------------------------------------------------------------
// siab_geom: configuration registers and icon placement
// Holds the registers and derives the fitted size, origin and clipped bounds
// with a bit-serial divider that runs after reset and after each write.
// ----------------------------------------------------------------------------
module siab_geom #(
  parameter int unsigned MAX_ICON_SIDE = siab_pkg::MAX_ICON_SIDE_DEF,
  parameter int unsigned SLOT_SIZE     = siab_pkg::SLOT_SIZE_DEF,
  localparam int unsigned SW = $clog2(MAX_ICON_SIDE + 1),
  localparam int unsigned FW = $clog2(SLOT_SIZE + 1) + 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [siab_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [siab_pkg::CFG_DW-1:0]  cfg_data_i,
  output logic                         busy_o,
  output siab_pkg::geom_t              geom_o,
  output logic [SW-1:0]                width_o,
  output logic [SW-1:0]                height_o,
  output logic [FW-1:0]                draw_w_o,
  output logic [FW-1:0]                draw_h_o
);

  localparam int unsigned XW       = siab_pkg::XW;
  localparam int unsigned BW       = siab_pkg::BW;
  localparam int unsigned NW       = SW + FW;
  localparam int unsigned CNT_LOAD = NW + 5;
  localparam int unsigned CNTW     = $clog2(CNT_LOAD + 1);
  localparam logic [FW-1:0] SLOT_FX = FW'(SLOT_SIZE * 65536);
  localparam logic [8:0]    MAX9    = 9'(MAX_ICON_SIDE);

  logic [6:0]         icon_w_q, icon_h_q;
  logic signed [11:0] slot_left_q, slot_top_q;
  logic [11:0]        clip_left_q, clip_top_q;
  logic [12:0]        clip_right_q, clip_bottom_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icon_w_q      <= 7'd16;
      icon_h_q      <= 7'd16;
      slot_left_q   <= '0;
      slot_top_q    <= '0;
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_right_q  <= 13'd4096;
      clip_bottom_q <= 13'd4096;
    end else if (cfg_valid_i) begin
      case (siab_pkg::cfg_reg_e'(cfg_index_i))
        siab_pkg::CFG_ICON_WIDTH:  icon_w_q      <= cfg_data_i[6:0];
        siab_pkg::CFG_ICON_HEIGHT: icon_h_q      <= cfg_data_i[6:0];
        siab_pkg::CFG_SLOT_LEFT:   slot_left_q   <= $signed(cfg_data_i[11:0]);
        siab_pkg::CFG_SLOT_TOP:    slot_top_q    <= $signed(cfg_data_i[11:0]);
        siab_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_data_i[11:0];
        siab_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_data_i[11:0];
        siab_pkg::CFG_CLIP_RIGHT:  clip_right_q  <= cfg_data_i;
        siab_pkg::CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective sides saturate at the largest icon side.
  logic [8:0]    w9, h9;
  logic [SW-1:0] w_eff, h_eff, side_max, side_min;
  assign w9       = {2'b00, icon_w_q};
  assign h9       = {2'b00, icon_h_q};
  assign w_eff    = (w9 > MAX9) ? SW'(MAX9) : SW'(w9);
  assign h_eff    = (h9 > MAX9) ? SW'(MAX9) : SW'(h9);
  assign side_max = (w_eff > h_eff) ? w_eff : h_eff;
  assign side_min = (w_eff > h_eff) ? h_eff : w_eff;

  // Sequencer: load, one quotient bit per cycle, then settle the derived values.
  logic [CNTW-1:0] cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNTW'(CNT_LOAD);
    end else if (cfg_valid_i) begin
      cnt_q <= CNTW'(CNT_LOAD);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end
  assign busy_o = (cnt_q != '0);

  // Restoring divider for the short side: side_min * slot / side_max.
  logic [NW-1:0] nd_q, quo_q, nd_load;
  logic [SW:0]   rem_q, rem_sh;
  logic          rem_ge;
  assign nd_load = (NW'(side_min) * NW'(SLOT_SIZE)) << 16;
  assign rem_sh  = {rem_q[SW-1:0], nd_q[NW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, side_max});

  always_ff @(posedge clk_i) begin
    if (cnt_q == CNTW'(CNT_LOAD)) begin
      nd_q  <= nd_load;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q > CNTW'(4)) begin
      nd_q  <= nd_q << 1;
      rem_q <= rem_ge ? (rem_sh - {1'b0, side_max}) : rem_sh;
      quo_q <= {quo_q[NW-2:0], rem_ge};
    end
  end

  // Fitted size, origin and clipped bounds, refreshed every cycle.
  logic [FW-1:0]         dw_q, dh_q;
  logic signed [XW-1:0]  dx_q, dy_q, ex_sum, ey_sum;
  siab_pkg::geom_t       geom_q;
  logic signed [BW-1:0]  fx0, fy0, fx1, fy1, cl, ct, cr, cb;

  assign ex_sum = dx_q + $signed(XW'(dw_q));
  assign ey_sum = dy_q + $signed(XW'(dh_q));
  assign fx0    = dx_q[XW-1:16];
  assign fy0    = dy_q[XW-1:16];
  assign fx1    = ex_sum[XW-1:16];
  assign fy1    = ey_sum[XW-1:16];
  assign cl     = $signed({2'b00, clip_left_q});
  assign ct     = $signed({2'b00, clip_top_q});
  assign cr     = $signed({1'b0, clip_right_q});
  assign cb     = $signed({1'b0, clip_bottom_q});

  always_ff @(posedge clk_i) begin
    dw_q <= (w_eff == side_max) ? SLOT_FX : quo_q[FW-1:0];
    dh_q <= (h_eff == side_max) ? SLOT_FX : quo_q[FW-1:0];
    dx_q <= (XW'(slot_left_q) <<< 16) + $signed(XW'((SLOT_FX - dw_q) >> 1));
    dy_q <= (XW'(slot_top_q) <<< 16) + $signed(XW'((SLOT_FX - dh_q) >> 1));
    geom_q.empty  <= (w_eff == '0) || (h_eff == '0);
    geom_q.draw_x <= dx_q;
    geom_q.draw_y <= dy_q;
    geom_q.x_lo   <= (fx0 < cl) ? cl : fx0;
    geom_q.y_lo   <= (fy0 < ct) ? ct : fy0;
    geom_q.x_hi   <= (fx1 > cr) ? cr : fx1;
    geom_q.y_hi   <= (fy1 > cb) ? cb : fy1;
  end

  assign geom_o   = geom_q;
  assign width_o  = w_eff;
  assign height_o = h_eff;
  assign draw_w_o = dw_q;
  assign draw_h_o = dh_q;

endmodule

/* rtl/siab_coord.sv */
// ----------------------------------------------------------------------------
// siab_coord: coverage test and source texel coordinates
// Pipeline: input register, offset and coverage, scale by icon side, then one
// restoring division stage per quotient bit.
// ----------------------------------------------------------------------------
module siab_coord #(
  parameter int unsigned MAX_ICON_SIDE = siab_pkg::MAX_ICON_SIDE_DEF,
  parameter int unsigned SLOT_SIZE     = siab_pkg::SLOT_SIZE_DEF,
  localparam int unsigned SW = $clog2(MAX_ICON_SIDE + 1),
  localparam int unsigned FW = $clog2(SLOT_SIZE + 1) + 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  siab_pkg::in_item_t in_item_i,
  input  siab_pkg::geom_t    geom_i,
  input  logic [SW-1:0]      width_i,
  input  logic [SW-1:0]      height_i,
  input  logic [FW-1:0]      draw_w_i,
  input  logic [FW-1:0]      draw_h_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output siab_pkg::in_item_t out_item_o,
  output logic               out_cover_o,
  output logic [SW-1:0]      out_sx_o,
  output logic [SW-1:0]      out_sy_o
);

  localparam int unsigned XW  = siab_pkg::XW;
  localparam int unsigned BW  = siab_pkg::BW;
  localparam int unsigned NWP = FW + SW;
  localparam int unsigned NS  = 3 + SW;

  logic               v_q   [NS];
  logic               rdy   [NS];
  siab_pkg::in_item_t item_q[NS];
  logic               cov_q [1:NS-1];
  logic               negx_q[1:NS-1];
  logic               negy_q[1:NS-1];

  // Stage advance: a stage takes new data when empty or when it moves on.
  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Offset from the fitted origin and coverage of the clipped rectangle.
  logic signed [XW-1:0] offx, offy;
  logic signed [BW-1:0] pxs, pys;
  logic                 cov_d;
  assign pxs  = $signed({2'b00, item_q[0].pixel_x});
  assign pys  = $signed({2'b00, item_q[0].pixel_y});
  assign offx = $signed({2'b00, item_q[0].pixel_x, 16'h0000}) - geom_i.draw_x;
  assign offy = $signed({2'b00, item_q[0].pixel_y, 16'h0000}) - geom_i.draw_y;
  assign cov_d = (item_q[0].opcode == siab_pkg::OP_BLEND) && !geom_i.empty &&
                 (pxs >= geom_i.x_lo) && (pxs < geom_i.x_hi) &&
                 (pys >= geom_i.y_lo) && (pys < geom_i.y_hi);

  logic [FW-1:0]  offx_q, offy_q;
  logic [NWP-1:0] nx_q, ny_q;
  logic [NWP-1:0] rx_q[SW], ry_q[SW], rx_d[SW], ry_d[SW];
  logic [SW-1:0]  qx_q[SW], qy_q[SW], qx_d[SW], qy_d[SW];

  // Division stages, most significant quotient bit first.
  always_comb begin
    logic [NWP-1:0] r_x, r_y, dsx, dsy;
    logic [SW-1:0]  q_x, q_y;
    for (int k = 0; k < SW; k++) begin
      r_x = (k == 0) ? nx_q : rx_q[(k == 0) ? 0 : k - 1];
      r_y = (k == 0) ? ny_q : ry_q[(k == 0) ? 0 : k - 1];
      q_x = (k == 0) ? '0 : qx_q[(k == 0) ? 0 : k - 1];
      q_y = (k == 0) ? '0 : qy_q[(k == 0) ? 0 : k - 1];
      dsx = NWP'(draw_w_i) << (SW - 1 - k);
      dsy = NWP'(draw_h_i) << (SW - 1 - k);
      rx_d[k] = (r_x >= dsx) ? (r_x - dsx) : r_x;
      ry_d[k] = (r_y >= dsy) ? (r_y - dsy) : r_y;
      qx_d[k] = q_x | (SW'(r_x >= dsx) << (SW - 1 - k));
      qy_d[k] = q_y | (SW'(r_y >= dsy) << (SW - 1 - k));
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      item_q[0] <= in_item_i;
    end
    if (rdy[1]) begin
      item_q[1] <= item_q[0];
      cov_q[1]  <= cov_d;
      negx_q[1] <= offx[XW-1];
      negy_q[1] <= offy[XW-1];
      offx_q    <= offx[FW-1:0];
      offy_q    <= offy[FW-1:0];
    end
    for (int k = 2; k < NS; k++) begin
      if (rdy[k]) begin
        item_q[k] <= item_q[k-1];
        cov_q[k]  <= cov_q[k-1];
        negx_q[k] <= negx_q[k-1];
        negy_q[k] <= negy_q[k-1];
      end
    end
    if (rdy[2]) begin
      nx_q <= NWP'(offx_q) * NWP'(width_i);
      ny_q <= NWP'(offy_q) * NWP'(height_i);
    end
    for (int k = 0; k < SW; k++) begin
      if (rdy[3+k]) begin
        rx_q[k] <= rx_d[k];
        ry_q[k] <= ry_d[k];
        qx_q[k] <= qx_d[k];
        qy_q[k] <= qy_d[k];
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_item_o  = item_q[NS-1];
  assign out_cover_o = cov_q[NS-1];
  assign out_sx_o    = negx_q[NS-1] ? '0 : qx_q[SW-1];
  assign out_sy_o    = negy_q[NS-1] ? '0 : qy_q[SW-1];

endmodule

/* rtl/siab_shade.sv */
// ----------------------------------------------------------------------------
// siab_shade: texel store and alpha blend
// Pipeline: address, store access, alpha dimming, blend products, result.
// ----------------------------------------------------------------------------
module siab_shade #(
  parameter int unsigned MAX_ICON_SIDE = siab_pkg::MAX_ICON_SIDE_DEF,
  localparam int unsigned SW = $clog2(MAX_ICON_SIDE + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  siab_pkg::in_item_t  in_item_i,
  input  logic                in_cover_i,
  input  logic [SW-1:0]       in_sx_i,
  input  logic [SW-1:0]       in_sy_i,
  input  logic [SW-1:0]       width_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output siab_pkg::out_item_t out_item_o
);

  localparam int unsigned AW  = siab_pkg::STORE_AW;
  localparam int unsigned AFW = 2 * SW + 1;
  localparam int unsigned NS  = 5;

  logic               v_q   [NS];
  logic               rdy   [NS];
  siab_pkg::in_item_t item_q[NS-1];
  logic               cov_q [NS-1];

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Row-major texel address, wrapped to the store.
  logic [AFW-1:0] addr_full;
  logic [AW-1:0]  addr_q;
  assign addr_full = AFW'(in_sy_i) * AFW'(width_i) + AFW'(in_sx_i);

  // Texel store: loads write and blends read in the same stage, in item order.
  logic [31:0] store_mem [2**AW];
  logic [31:0] rdat_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      if (v_q[0] && (item_q[0].opcode == siab_pkg::OP_LOAD)) begin
        store_mem[item_q[0].texel_index] <= item_q[0].texel_rgba;
      end
      rdat_q <= store_mem[addr_q];
    end
  end

  // Alpha dimming.
  logic [7:0] a_raw, a_dim;
  assign a_raw = rdat_q[31:24];
  assign a_dim = item_q[1].dimmed ?
                 siab_pkg::div255(17'(a_raw) * 17'(siab_pkg::ALPHA_DIM) +
                                  siab_pkg::ROUND_HALF) : a_raw;

  logic [23:0] tex2_q, tex3_q;
  logic [7:0]  a2_q, a3_q;

  // Blend products with rounding term.
  logic [7:0]  inv_a;
  logic [16:0] pr_d, pg_d, pb_d, pa_d;
  logic [16:0] pr_q, pg_q, pb_q, pa_q;
  assign inv_a = siab_pkg::ALPHA_FULL - a2_q;
  assign pr_d  = 17'(tex2_q[7:0])   * 17'(a2_q) +
                 17'(item_q[2].dest_rgba[7:0])   * 17'(inv_a) + siab_pkg::ROUND_HALF;
  assign pg_d  = 17'(tex2_q[15:8])  * 17'(a2_q) +
                 17'(item_q[2].dest_rgba[15:8])  * 17'(inv_a) + siab_pkg::ROUND_HALF;
  assign pb_d  = 17'(tex2_q[23:16]) * 17'(a2_q) +
                 17'(item_q[2].dest_rgba[23:16]) * 17'(inv_a) + siab_pkg::ROUND_HALF;
  assign pa_d  = 17'(item_q[2].dest_rgba[31:24]) * 17'(inv_a) + siab_pkg::ROUND_HALF;

  // Final selection: no write, opaque copy or rounded blend.
  siab_pkg::out_item_t res_d, res_q;
  always_comb begin
    logic [7:0] da;
    da = a3_q + siab_pkg::div255(pa_q);
    res_d.out_rgba    = item_q[3].dest_rgba;
    res_d.write_pixel = 1'b0;
    if (cov_q[3] && (a3_q != siab_pkg::ALPHA_NONE)) begin
      res_d.write_pixel = 1'b1;
      if (a3_q == siab_pkg::ALPHA_FULL) begin
        res_d.out_rgba = {siab_pkg::ALPHA_FULL, tex3_q};
      end else begin
        res_d.out_rgba = {da, siab_pkg::div255(pb_q), siab_pkg::div255(pg_q),
                          siab_pkg::div255(pr_q)};
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      item_q[0] <= in_item_i;
      cov_q[0]  <= in_cover_i;
      addr_q    <= AW'(addr_full);
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        item_q[k] <= item_q[k-1];
        cov_q[k]  <= cov_q[k-1];
      end
    end
    if (rdy[2]) begin
      tex2_q <= rdat_q[23:0];
      a2_q   <= a_dim;
    end
    if (rdy[3]) begin
      tex3_q <= tex2_q;
      a3_q   <= a2_q;
      pr_q   <= pr_d;
      pg_q   <= pg_d;
      pb_q   <= pb_d;
      pa_q   <= pa_d;
    end
    if (rdy[4]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_item_o  = res_q;

endmodule

/* rtl/siab_checker.sv */
// ----------------------------------------------------------------------------
// siab_checker: port-level checks of the scaled icon alpha blitter
// Watches the handshakes and the configuration hold-off at the top level.
// ----------------------------------------------------------------------------
module siab_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input siab_pkg::out_item_t out_item_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o
);

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed or dropped while stalled");

  // The placement is recomputed after a write, so no item may enter next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("item accepted right after a configuration write");

  // Coming out of reset the placement is not yet ready.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !in_ready_o)
    else $error("input ready while leaving reset");

  // Every stage is empty when reset is released.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid while leaving reset");

endmodule

bind scaled_icon_alpha_blit siab_checker u_siab_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o)
);
